[rtl/sfd_pkg.sv]
package sfd_pkg;

	// SLIP special characters
	localparam logic [7:0] SLIP_END     = 8'hC0;
	localparam logic [7:0] SLIP_ESC     = 8'hDB;
	localparam logic [7:0] SLIP_ESC_END = 8'hDC;
	localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

	localparam int unsigned CAP_W = 12;
	localparam logic [CAP_W-1:0] CAP_RESET = 12'd1006;

	// result kinds
	localparam logic [1:0] KIND_PAYLOAD = 2'd0;
	localparam logic [1:0] KIND_DONE    = 2'd1;
	localparam logic [1:0] KIND_DROP    = 2'd2;

	// result queue geometry
	localparam int unsigned RQ_DEPTH = 4;
	localparam int unsigned RQ_PTR_W = $clog2(RQ_DEPTH);
	localparam int unsigned RQ_CNT_W = $clog2(RQ_DEPTH + 1);

	typedef struct packed {
		logic [1:0]       kind;
		logic [7:0]       data_byte;
		logic [CAP_W-1:0] frame_length;
		logic             last;
	} result_t;

	// up to two results written per decoded byte
	typedef struct packed {
		logic [1:0] n;
		result_t    r1;
		result_t    r0;
	} push_t;

endpackage

[rtl/sfd_decode.sv]
module sfd_decode import sfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic [CAP_W-1:0] cap,
	input  logic             room,
	output push_t            push
);

	typedef enum logic [1:0] {
		PH_IDLE   = 2'd0,
		PH_RECV   = 2'd1,
		PH_ESCAPE = 2'd2
	} phase_t;

	phase_t           phase_q, phase_nx;
	logic [CAP_W-1:0] count_q, count_nx;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             advance;
	result_t          res [2];
	logic [1:0]       n;

	// hold a byte in the input stage until the queue has room for two results
	assign advance  = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	// decode one byte into at most two results
	always_comb begin
		logic ovf;
		phase_t ph;
		logic [CAP_W-1:0] c;
		logic [7:0] pay0, pay1;
		logic want0, want1;

		res[0]   = '0;
		res[1]   = '0;
		n        = 2'd0;
		pay0     = '0;
		pay1     = '0;
		want0    = 1'b0;
		want1    = 1'b0;
		ovf      = (count_q >= cap);
		ph       = ovf ? PH_IDLE : phase_q;
		c        = ovf ? '0 : count_q;
		phase_nx = PH_RECV;

		// overflow: drop the partial frame, then treat the byte from idle
		if (ovf) begin
			res[0].kind = KIND_DROP;
			n = 2'd1;
		end

		case (ph)
			PH_RECV: begin
				if (byte_s1 == SLIP_ESC) begin
					phase_nx = PH_ESCAPE;
				end else if (byte_s1 == SLIP_END) begin
					if (c != '0) begin
						res[0].kind         = KIND_DONE;
						res[0].frame_length = c;
						n = 2'd1;
					end
					c = '0;
					phase_nx = PH_IDLE;
				end else begin
					want0 = 1'b1;
					pay0  = byte_s1;
				end
			end
			PH_ESCAPE: begin
				want0 = 1'b1;
				if (byte_s1 == SLIP_ESC_END) begin
					pay0 = SLIP_END;
				end else if (byte_s1 == SLIP_ESC_ESC) begin
					pay0 = SLIP_ESC;
				end else begin
					pay0  = SLIP_ESC;
					want1 = 1'b1;
					pay1  = byte_s1;
				end
			end
			default: begin
				if (byte_s1 != SLIP_END) begin
					want0 = 1'b1;
					pay0  = byte_s1;
				end
			end
		endcase

		// payload bytes past capacity are dropped silently
		if (want0 && (c < cap)) begin
			c = CAP_W'(c + 1'b1);
			res[n[0]].kind      = KIND_PAYLOAD;
			res[n[0]].data_byte = pay0;
			n = n + 2'd1;
		end
		if (want1 && (c < cap)) begin
			c = CAP_W'(c + 1'b1);
			res[n[0]].kind      = KIND_PAYLOAD;
			res[n[0]].data_byte = pay1;
			n = n + 2'd1;
		end

		if (n == 2'd2) begin
			res[1].last = 1'b1;
		end else if (n == 2'd1) begin
			res[0].last = 1'b1;
		end
		count_nx = c;
	end

	assign push.n  = advance ? n : 2'd0;
	assign push.r0 = res[0];
	assign push.r1 = res[1];

	// input stage and frame state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= PH_IDLE;
			count_q  <= '0;
		end else begin
			if (in_valid && in_ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				phase_q <= phase_nx;
				count_q <= count_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

[rtl/sfd_result_fifo.sv]
module sfd_result_fifo import sfd_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  push_t   push,
	output logic    room,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_res
);

	result_t             mem_q [RQ_DEPTH];
	logic [RQ_PTR_W-1:0] wr_ptr_q, rd_ptr_q, wr_ptr_nx1;
	logic [RQ_CNT_W-1:0] count_q;
	logic                pop;

	assign out_valid  = (count_q != '0);
	assign out_res    = mem_q[rd_ptr_q];
	assign pop        = out_valid && out_ready;
	assign room       = (count_q <= RQ_CNT_W'(RQ_DEPTH - 2));
	assign wr_ptr_nx1 = RQ_PTR_W'(wr_ptr_q + 1'b1);

	// write up to two results at the tail
	always_ff @(posedge clk) begin
		if (push.n != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.n == 2'd2) begin
			mem_q[wr_ptr_nx1] <= push.r1;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= RQ_PTR_W'(wr_ptr_q + push.n);
			if (pop) begin
				rd_ptr_q <= RQ_PTR_W'(rd_ptr_q + 1'b1);
			end
			count_q <= RQ_CNT_W'(count_q + RQ_CNT_W'(push.n) - RQ_CNT_W'(pop));
		end
	end

endmodule

[rtl/slip_frame_decoder.sv]
// SLIP receive deframer. One line byte is taken per request on in_valid/in_ready and
// turned into zero, one or two results on out_valid/out_ready: a payload byte (kind 0),
// a frame-complete marker with its length (kind 1), or a frame-dropped marker (kind 2)
// when a frame reaches the capacity set through cfg_we/cfg_wdata (reset 1006). last marks
// the final result of each byte. A byte is accepted every cycle while the result queue
// has room, and results drain at one per cycle while out_ready is high; a byte yielding
// two results (an escape followed by an unexpected character, or an overflow) fills two
// queue entries. Bytes pass the input stage, then the four-entry result queue, whose need
// for two free entries sets when the input is ready. Write the capacity only when idle.
module slip_frame_decoder import sfd_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       kind,
	output logic [7:0]       data_byte,
	output logic [CAP_W-1:0] frame_length,
	output logic             last,
	input  logic             cfg_we,
	input  logic [CAP_W-1:0] cfg_wdata
);

	logic [CAP_W-1:0] cap_q;
	push_t            push;
	logic             room;
	result_t          res;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	sfd_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.cap      (cap_q),
		.room     (room),
		.push     (push)
	);

	sfd_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_res   (res)
	);

	assign kind         = res.kind;
	assign data_byte    = res.data_byte;
	assign frame_length = res.frame_length;
	assign last         = res.last;

endmodule

[rtl/sfd_checker.sv]
module sfd_checker import sfd_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             out_valid,
	input logic             out_ready,
	input logic [1:0]       kind,
	input logic [7:0]       data_byte,
	input logic [CAP_W-1:0] frame_length,
	input logic             last
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(data_byte)
			&& $stable(frame_length) && $stable(last))
		else $error("result changed while stalled");

	// never show an unused kind
	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (kind == KIND_PAYLOAD || kind == KIND_DONE || kind == KIND_DROP))
		else $error("unused result kind");

	// a completed frame carries a non-zero length and no data
	a_done_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_DONE |-> frame_length != '0 && data_byte == '0)
		else $error("frame-complete result malformed");

	// payload and drop results carry no length
	a_no_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind != KIND_DONE |-> frame_length == '0)
		else $error("length on a non-complete result");

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (.*);
